### rtl/dale_pkg.sv
// Shared constants and codes for the deduplicating array list engine.
// No dependencies.
`timescale 1ns / 1ps
package dale_pkg;
    localparam int CAPACITY    = 32;
    localparam int MAX_RESULTS = 32;
    localparam int AW          = $clog2(CAPACITY);
    localparam int CW          = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        KIND_APPEND  = 3'd0,
        KIND_INSERT  = 3'd1,
        KIND_FIND_L  = 3'd2,
        KIND_FIND_B  = 3'd3,
        KIND_DEL_AT  = 3'd4,
        KIND_DEL_VAL = 3'd5,
        KIND_SORT    = 3'd6,
        KIND_READ    = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_FULL       = 3'd2,
        ST_BAD_POS    = 3'd3,
        ST_NOT_SORTED = 3'd4,
        ST_EMPTY      = 3'd5
    } status_t;

    // Signed compare of two keys.
    function automatic logic key_less(input logic [31:0] a, input logic [31:0] b);
        key_less = $signed(a) < $signed(b);
    endfunction
endpackage

### rtl/dale_mem.sv
// Entry storage for the list: one write port, one registered read port.
// Depends on dale_pkg.
`timescale 1ns / 1ps
module dale_mem
    import dale_pkg::*;
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/deduplicating_array_list_engine_top.sv
// Top level of the deduplicating array list engine: sequencer around one
// entry memory. Depends on dale_pkg, dale_mem.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready) carries kind, key, slot. Output
//   channel (out_valid/out_ready) carries status, found_slot, entry, fill,
//   last. One request is worked on at a time; in_ready is low meanwhile.
//   Every command gives one result except read list, which gives one per
//   entry (last marks the final one) or one "empty" result.
//   Each entry visited costs a read state and then a compare or write
//   state, as the entry memory has a registered read port. Append and
//   insert run a dedupe scan and then a shift; sort is a selection sort.
//   Reset clears count, sorted flag and control state; entries are
//   undefined until written and are never read beyond the count.
//   When the receiver stalls the result holds in the output register and
//   the sequencer waits; no result is lost.
module deduplicating_array_list_engine_top
    import dale_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         kind,
    input  logic signed [31:0] key,
    input  logic [7:0]         slot,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [5:0]         found_slot,
    output logic signed [31:0] entry,
    output logic [5:0]         fill,
    output logic               last
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_LSCAN, S_LCHK, S_BPROBE, S_BCHK,
        S_DSHIFT_RD, S_DSHIFT_WR, S_ADD, S_ISHIFT_RD, S_ISHIFT_WR,
        S_SRD, S_SCHK, S_SSWAP, S_RD, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        P_NONE, P_APPEND, P_INSERT, P_DELVAL, P_FIND
    } post_t;

    state_t            state_reg, state_next;
    post_t             post_reg, post_next;
    kind_t             kind_reg, kind_next;
    logic [31:0]       key_reg, key_next;
    logic [7:0]        slot_reg, slot_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic              sorted_reg, sorted_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [CW-1:0]     m_reg, m_next;
    logic [CW:0]       lo_reg, lo_next, hi_reg, hi_next;
    logic [31:0]       hold_reg, hold_next;
    logic [31:0]       mval_reg, mval_next;
    logic              swap_ph_reg, swap_ph_next;
    logic [CW-1:0]     res_slot_reg, res_slot_next;
    logic              ov_reg, ov_next;
    logic [2:0]        st_reg, st_next;
    logic [5:0]        fs_reg, fs_next;
    logic [31:0]       en_reg, en_next;
    logic              last_reg, last_next;
    state_t            ret_reg, ret_next;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [31:0]       wdata, rdata;
    logic [CW:0]       mid;

    dale_mem u_mem (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = ov_reg;
    assign status     = st_reg;
    assign found_slot = fs_reg;
    assign entry      = en_reg;
    assign fill       = 6'(fill_reg);
    assign last       = last_reg;
    assign mid        = (lo_reg + hi_reg) >> 1;

    always_comb
    begin
        state_next    = state_reg;
        post_next     = post_reg;
        kind_next     = kind_reg;
        key_next      = key_reg;
        slot_next     = slot_reg;
        fill_next     = fill_reg;
        sorted_next   = sorted_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        m_next        = m_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        hold_next     = hold_reg;
        mval_next     = mval_reg;
        swap_ph_next  = swap_ph_reg;
        res_slot_next = res_slot_reg;
        ov_next       = ov_reg;
        st_next       = st_reg;
        fs_next       = fs_reg;
        en_next       = en_reg;
        last_next     = last_reg;
        ret_next      = ret_reg;
        we            = 1'b0;
        waddr         = '0;
        wdata         = '0;
        raddr         = i_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind_t'(kind);
                    key_next   = key;
                    slot_next  = slot;
                    i_next     = '0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                st_next   = ST_OK;
                fs_next   = '0;
                en_next   = '0;
                last_next = 1'b1;
                ret_next  = S_IDLE;
                i_next    = '0;
                unique case (kind_reg)
                    KIND_APPEND, KIND_INSERT:
                    begin
                        if (fill_reg >= CW'(CAPACITY))
                        begin
                            st_next = ST_FULL;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            post_next  = (kind_reg == KIND_APPEND) ? P_APPEND : P_INSERT;
                            state_next = S_LSCAN;
                        end
                    end
                    KIND_FIND_L:
                    begin
                        post_next  = P_FIND;
                        state_next = S_LSCAN;
                    end
                    KIND_FIND_B:
                    begin
                        if (!sorted_reg)
                        begin
                            st_next = ST_NOT_SORTED;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            lo_next    = '0;
                            hi_next    = (CW+1)'(fill_reg);
                            state_next = S_BPROBE;
                        end
                    end
                    KIND_DEL_AT:
                    begin
                        if (fill_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                            state_next = S_OUT;
                        end
                        else if (slot_reg == 8'd0 || slot_reg > 8'(fill_reg))
                        begin
                            st_next = ST_BAD_POS;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            post_next     = P_NONE;
                            res_slot_next = CW'(slot_reg);
                            i_next        = CW'(slot_reg);
                            state_next    = S_DSHIFT_RD;
                        end
                    end
                    KIND_DEL_VAL:
                    begin
                        if (fill_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            post_next  = P_DELVAL;
                            state_next = S_LSCAN;
                        end
                    end
                    KIND_SORT:
                    begin
                        sorted_next  = 1'b1;
                        swap_ph_next = 1'b0;
                        state_next   = S_SRD;
                    end
                    KIND_READ:
                    begin
                        if (fill_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            // Linear scan: issue read of entry i, then compare.
            S_LSCAN:
            begin
                if (i_reg >= fill_reg)
                begin
                    // not found
                    unique case (post_reg)
                        P_FIND, P_DELVAL:
                        begin
                            st_next = ST_NOT_FOUND;
                            state_next = S_OUT;
                        end
                        P_APPEND:
                        begin
                            state_next = S_ADD;
                        end
                        default:
                        begin
                            state_next = S_ADD;
                        end
                    endcase
                end
                else
                begin
                    raddr      = i_reg[AW-1:0];
                    state_next = S_LCHK;
                end
            end
            S_LCHK:
            begin
                if (rdata == key_reg)
                begin
                    unique case (post_reg)
                        P_FIND:
                        begin
                            fs_next = 6'(i_reg + 1'b1);
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            res_slot_next = i_reg + 1'b1;
                            i_next        = i_reg + 1'b1;
                            state_next    = S_DSHIFT_RD;
                        end
                    endcase
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_LSCAN;
                end
            end
            // Binary search over [lo, hi).
            S_BPROBE:
            begin
                if (lo_reg >= hi_reg)
                begin
                    st_next = ST_NOT_FOUND;
                    state_next = S_OUT;
                end
                else
                begin
                    raddr      = mid[AW-1:0];
                    state_next = S_BCHK;
                end
            end
            S_BCHK:
            begin
                if (rdata == key_reg)
                begin
                    fs_next = 6'(mid + 1'b1);
                    state_next = S_OUT;
                end
                else
                begin
                    if (key_less(key_reg, rdata))
                        hi_next = mid;
                    else
                        lo_next = mid + 1'b1;
                    state_next = S_BPROBE;
                end
            end
            // Remove at res_slot: move entries i..fill-1 down by one.
            S_DSHIFT_RD:
            begin
                if (i_reg >= fill_reg)
                begin
                    fill_next = fill_reg - 1'b1;
                    i_next    = '0;
                    unique case (post_reg)
                        P_APPEND, P_INSERT: state_next = S_ADD;
                        default:
                        begin
                            fs_next = 6'(res_slot_reg);
                            state_next = S_OUT;
                        end
                    endcase
                end
                else
                begin
                    raddr      = i_reg[AW-1:0];
                    state_next = S_DSHIFT_WR;
                end
            end
            S_DSHIFT_WR:
            begin
                we         = 1'b1;
                waddr      = AW'(i_reg - 1'b1);
                wdata      = rdata;
                i_next     = i_reg + 1'b1;
                state_next = S_DSHIFT_RD;
            end
            S_ADD:
            begin
                if (post_reg == P_APPEND)
                begin
                    we          = 1'b1;
                    waddr       = fill_reg[AW-1:0];
                    wdata       = key_reg;
                    fill_next   = fill_reg + 1'b1;
                    sorted_next = 1'b0;
                    fs_next     = 6'(fill_reg + 1'b1);
                    state_next  = S_OUT;
                end
                else if (slot_reg == 8'd0 || slot_reg > 8'(fill_reg) + 8'd1)
                begin
                    st_next    = ST_BAD_POS;
                    state_next = S_OUT;
                end
                else
                begin
                    i_next     = fill_reg;
                    state_next = S_ISHIFT_RD;
                end
            end
            // Open a hole at slot-1 by moving entries up from the top.
            S_ISHIFT_RD:
            begin
                if (i_reg < CW'(slot_reg))
                begin
                    we          = 1'b1;
                    waddr       = AW'(slot_reg - 8'd1);
                    wdata       = key_reg;
                    fill_next   = fill_reg + 1'b1;
                    sorted_next = 1'b0;
                    fs_next     = 6'(slot_reg);
                    state_next  = S_OUT;
                end
                else
                begin
                    raddr      = AW'(i_reg - 1'b1);
                    state_next = S_ISHIFT_WR;
                end
            end
            S_ISHIFT_WR:
            begin
                we         = 1'b1;
                waddr      = i_reg[AW-1:0];
                wdata      = rdata;
                i_next     = i_reg - 1'b1;
                state_next = S_ISHIFT_RD;
            end
            // Selection sort: i outer, j scan, m min index.
            S_SRD:
            begin
                if (i_reg + 1'b1 >= fill_reg || fill_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    raddr      = i_reg[AW-1:0];
                    m_next     = i_reg;
                    j_next     = i_reg;
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                // j_reg is the index whose data is on rdata now
                if (j_reg == i_reg || key_less(rdata, mval_reg))
                begin
                    mval_next = rdata;
                    m_next    = j_reg;
                end
                if (j_reg == i_reg)
                    hold_next = rdata;
                if (j_reg + 1'b1 < fill_reg)
                begin
                    raddr  = AW'(j_reg + 1'b1);
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    swap_ph_next = 1'b0;
                    state_next   = S_SSWAP;
                end
            end
            S_SSWAP:
            begin
                we = 1'b1;
                if (!swap_ph_reg)
                begin
                    waddr        = m_reg[AW-1:0];
                    wdata        = hold_reg;
                    swap_ph_next = 1'b1;
                end
                else
                begin
                    waddr      = i_reg[AW-1:0];
                    wdata      = mval_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            // Read list: fetch entry i then present it.
            S_RD:
            begin
                raddr      = i_reg[AW-1:0];
                ret_next   = S_RD;
                state_next = S_OUT;
                ov_next    = 1'b0;
                // data is taken in S_OUT on the following cycle
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    if (kind_reg == KIND_READ && fill_reg != '0)
                    begin
                        st_next   = ST_OK;
                        fs_next   = 6'(i_reg + 1'b1);
                        en_next   = rdata;
                        last_next = (i_reg + 1'b1 == fill_reg)
                                    || (i_reg + 1'b1 == CW'(MAX_RESULTS));
                    end
                end
                else if (out_ready)
                begin
                    ov_next = 1'b0;
                    if (kind_reg == KIND_READ && !last_reg)
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            sorted_reg  <= 1'b0;
            ov_reg      <= 1'b0;
            post_reg    <= P_NONE;
            kind_reg    <= KIND_APPEND;
            ret_reg     <= S_IDLE;
            swap_ph_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            sorted_reg  <= sorted_next;
            ov_reg      <= ov_next;
            post_reg    <= post_next;
            kind_reg    <= kind_next;
            ret_reg     <= ret_next;
            swap_ph_reg <= swap_ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        slot_reg     <= slot_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        m_reg        <= m_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        hold_reg     <= hold_next;
        mval_reg     <= mval_next;
        res_slot_reg <= res_slot_next;
        st_reg       <= st_next;
        fs_reg       <= fs_next;
        en_reg       <= en_next;
        last_reg     <= last_next;
    end

    // Output only while the sequencer sits in its result state.
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT)
        else $error("result shown outside result state");
    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("fill beyond capacity");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("ready while busy");
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(found_slot))
        else $error("stalled result changed");
endmodule

### tb/tb_top.sv
// Self-checking testbench for the deduplicating array list engine.
// Drives list requests, predicts results with a scoreboard class; needs dale_pkg and the top.
`timescale 1ns / 1ps
module tb_top;
    import dale_pkg::*;

    class list_scoreboard;
        logic signed [31:0] keys [CAPACITY];
        int count;
        bit sorted_flag;
        logic [2:0]  q_status [$];
        logic [5:0]  q_slot [$];
        logic [31:0] q_entry [$];
        logic [5:0]  q_fill [$];
        logic        q_last [$];
        int errors;

        function new();
            count = 0;
            sorted_flag = 0;
            errors = 0;
        endfunction

        function void push(status_t st, int sl, logic [31:0] en, bit lst);
            q_status.push_back(st);
            q_slot.push_back(sl[5:0]);
            q_entry.push_back(en);
            q_fill.push_back(count[5:0]);
            q_last.push_back(lst);
        endfunction

        function int scan(logic signed [31:0] k);
            for (int i = 0; i < count; i++)
                if (keys[i] == k) return i + 1;
            return 0;
        endfunction

        function int bsearch(logic signed [31:0] k);
            int lo, hi, mid;
            lo = 0;
            hi = count - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (keys[mid] == k) return mid + 1;
                if (k < keys[mid]) hi = mid - 1;
                else lo = mid + 1;
            end
            return 0;
        endfunction

        function void drop(int pos);
            for (int i = pos; i < count; i++) keys[i-1] = keys[i];
            count--;
        endfunction

        function void note_request(kind_t k, logic signed [31:0] kv, int sl);
            int p, m, n;
            logic signed [31:0] t;
            case (k)
                KIND_APPEND, KIND_INSERT:
                begin
                    if (count >= CAPACITY) begin
                        push(ST_FULL, 0, 0, 1);
                        return;
                    end
                    p = scan(kv);
                    if (p != 0) drop(p);
                    if (k == KIND_APPEND) begin
                        keys[count] = kv;
                        count++;
                        sorted_flag = 0;
                        push(ST_OK, count, 0, 1);
                    end
                    else if (sl < 1 || sl > count + 1) begin
                        push(ST_BAD_POS, 0, 0, 1);
                    end
                    else begin
                        for (int i = count; i >= sl; i--) keys[i] = keys[i-1];
                        keys[sl-1] = kv;
                        count++;
                        sorted_flag = 0;
                        push(ST_OK, sl, 0, 1);
                    end
                end
                KIND_FIND_L, KIND_FIND_B:
                begin
                    if (k == KIND_FIND_B && !sorted_flag) begin
                        push(ST_NOT_SORTED, 0, 0, 1);
                        return;
                    end
                    p = (k == KIND_FIND_L) ? scan(kv) : bsearch(kv);
                    push(p != 0 ? ST_OK : ST_NOT_FOUND, p, 0, 1);
                end
                KIND_DEL_AT:
                begin
                    if (count == 0) push(ST_EMPTY, 0, 0, 1);
                    else if (sl < 1 || sl > count) push(ST_BAD_POS, 0, 0, 1);
                    else begin
                        drop(sl);
                        push(ST_OK, sl, 0, 1);
                    end
                end
                KIND_DEL_VAL:
                begin
                    if (count == 0) push(ST_EMPTY, 0, 0, 1);
                    else begin
                        p = scan(kv);
                        if (p == 0) push(ST_NOT_FOUND, 0, 0, 1);
                        else begin
                            drop(p);
                            push(ST_OK, p, 0, 1);
                        end
                    end
                end
                KIND_SORT:
                begin
                    for (int i = 0; i + 1 < count; i++) begin
                        m = i;
                        for (int j = i + 1; j < count; j++)
                            if (keys[j] < keys[m]) m = j;
                        t = keys[i];
                        keys[i] = keys[m];
                        keys[m] = t;
                    end
                    sorted_flag = 1;
                    push(ST_OK, 0, 0, 1);
                end
                default:
                begin
                    n = (count > MAX_RESULTS) ? MAX_RESULTS : count;
                    if (n == 0) push(ST_EMPTY, 0, 0, 1);
                    for (int i = 0; i < n; i++) push(ST_OK, i + 1, keys[i], i + 1 == n);
                end
            endcase
        endfunction

        function void check_result(logic [2:0] st, logic [5:0] sl, logic [31:0] en,
                                   logic [5:0] fl, logic lst);
            if (q_status.size() == 0) begin
                $display("%0t: unexpected result status=%0d slot=%0d", $time, st, sl);
                errors++;
                return;
            end
            if (st !== q_status[0] || sl !== q_slot[0] || en !== q_entry[0] ||
                fl !== q_fill[0] || lst !== q_last[0]) begin
                $display("%0t: mismatch exp st=%0d sl=%0d en=%h fill=%0d last=%0b",
                         $time, q_status[0], q_slot[0], q_entry[0], q_fill[0], q_last[0]);
                $display("%0t:          got st=%0d sl=%0d en=%h fill=%0d last=%0b",
                         $time, st, sl, en, fl, lst);
                errors++;
            end
            void'(q_status.pop_front());
            void'(q_slot.pop_front());
            void'(q_entry.pop_front());
            void'(q_fill.pop_front());
            void'(q_last.pop_front());
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0, out_ready = 0;
    logic in_ready, out_valid;
    logic [2:0] kind = 0;
    logic signed [31:0] key = 0;
    logic [7:0] slot = 0;
    logic [2:0] status;
    logic [5:0] found_slot, fill;
    logic signed [31:0] entry;
    logic last;
    bit hold_off = 0;
    longint cycles = 0;
    list_scoreboard sb = new();
    logic signed [31:0] pool [8];

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    deduplicating_array_list_engine_top i_dut (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        if (out_valid && out_ready) sb.check_result(status, found_slot, entry, fill, last);

    // Keep valid high into the next request when there is no gap.
    task automatic send(kind_t k, logic signed [31:0] kv, logic [7:0] sl);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        kind <= k;
        key <= kv;
        slot <= sl;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(k, kv, sl);
    endtask

    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom();
            default: return pool[$urandom_range(0, 7)];
        endcase
    endfunction

    // Receiver: random stalls per result, plus one long hold-off.
    initial
    begin
        int w;
        @(posedge rst_n);
        forever begin
            if (hold_off) begin
                out_ready <= 0;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            if (w != 0)
            begin
                out_ready <= 0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        int r;
        pool = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, 5, 32'sh55aa55aa, 32'shaa55aa55};
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Empty-list cases, binary find refused, then extremes.
        send(KIND_READ, 0, 0);
        send(KIND_DEL_AT, 0, 1);
        send(KIND_DEL_VAL, 0, 0);
        send(KIND_FIND_L, 3, 0);
        send(KIND_FIND_B, 3, 0);
        send(KIND_SORT, 0, 0);
        send(KIND_FIND_B, 3, 0);
        send(KIND_APPEND, 32'sh7fffffff, 8'hff);
        send(KIND_APPEND, 32'sh80000000, 0);
        send(KIND_INSERT, -1, 1);
        send(KIND_INSERT, 5, 0);
        send(KIND_INSERT, 6, 8'hff);
        send(KIND_INSERT, 7, 4);
        send(KIND_APPEND, -1, 0);
        send(KIND_SORT, 0, 0);
        send(KIND_FIND_B, 32'sh80000000, 0);
        send(KIND_FIND_B, 32'sh7fffffff, 0);
        send(KIND_FIND_B, 2, 0);
        send(KIND_DEL_AT, 0, 0);
        send(KIND_DEL_AT, 0, 9);
        send(KIND_DEL_AT, 0, 2);
        send(KIND_DEL_VAL, 99, 0);
        send(KIND_DEL_VAL, 7, 0);
        send(KIND_READ, 0, 0);
        // Fill to capacity under a long receiver stall.
        hold_off = 1;
        for (int i = 0; i < 34; i++) send(KIND_APPEND, $urandom(), 0);
        send(KIND_INSERT, 1, 1);
        send(KIND_READ, 0, 0);
        for (int i = 0; i < 90; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30) send(KIND_APPEND, pick_key(), 0);
            else if (r < 45) send(KIND_INSERT, pick_key(),
                                  $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 34));
            else if (r < 55) send(KIND_FIND_L, pick_key(), $urandom());
            else if (r < 65) send(KIND_FIND_B, pick_key(), $urandom());
            else if (r < 75) send(KIND_DEL_AT, $urandom(),
                                  $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 33));
            else if (r < 85) send(KIND_DEL_VAL, pick_key(), $urandom());
            else if (r < 92) send(KIND_SORT, $urandom(), $urandom());
            else send(KIND_READ, $urandom(), $urandom());
        end
        in_valid <= 0;
        while (sb.q_status.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.q_status.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
